// ===== rtl/orc_pkg.sv =====
// ----------------------------------------------------------------------------
// Oriented rectangle collision: shared package
// Constants, fixed-point widths and the control word that runs along the
// pipeline beside the axis lanes.
// ----------------------------------------------------------------------------
package orc_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int ANGLE_WIDTH_DEF = 16;

	// Bits of the centre offset kept in the low part; the rest is the high part.
	localparam int LO_BITS = 20;
	// High-part width for the default coordinate width.
	localparam int HI_WIDTH_DEF = 6;

	// Sine and cosine are signed Q1.14 in a 16-bit word.
	localparam int TRIG_W = 16;

	localparam int NUM_AXES = 4;

	// Quarter-wave sine polynomial coefficients, Q30.
	localparam logic [30:0] POLY_A = 31'd1686629713;
	localparam logic [29:0] POLY_B = 30'd688904866;
	localparam logic [26:0] POLY_C = 27'd76016977;

	// Side information that travels alongside the lanes.
	typedef struct packed {
		logic want_proj;
		logic aligned;
		logic aligned_hit;
	} ctl_t;

endpackage

// ===== rtl/oriented_rect_collision.sv =====
// ----------------------------------------------------------------------------
// Oriented rectangle collision
// Separating-axis overlap test of two oriented rectangles, one pair per
// transfer, with four axis lanes working side by side.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle while the consumer does not stall; every
// stage has its own valid bit, so the pipeline keeps filling while a
// finished result waits for the consumer.
// The pipeline has 14 register stages (five for the sine units, eight
// per axis lane, one for the merge); each stage advances when it can.
// Reset: arst_n clears all valid bits asynchronously; data registers keep
// whatever they hold and are ignored until a valid item reaches them.
// ----------------------------------------------------------------------------
module oriented_rect_collision import orc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic [11:0]                   a_w,
	input  logic [11:0]                   a_h,
	input  logic [ANGLE_WIDTH-1:0]        a_angle,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic [11:0]                   b_w,
	input  logic [11:0]                   b_h,
	input  logic [ANGLE_WIDTH-1:0]        b_angle,
	input  logic                          want_projections,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [2:0]                    proj_count,
	output logic signed [COORD_WIDTH-1:0] proj0_x,
	output logic signed [COORD_WIDTH-1:0] proj0_y,
	output logic signed [COORD_WIDTH-1:0] proj1_x,
	output logic signed [COORD_WIDTH-1:0] proj1_y,
	output logic signed [COORD_WIDTH-1:0] proj2_x,
	output logic signed [COORD_WIDTH-1:0] proj2_y,
	output logic signed [COORD_WIDTH-1:0] proj3_x,
	output logic signed [COORD_WIDTH-1:0] proj3_y
);

	// Width of the centre offset; it must hold a coordinate difference and
	// the half-size correction, whichever is wider, plus their sum.
	localparam int DW  = ((COORD_WIDTH + 1 > LO_BITS) ? COORD_WIDTH + 1 : LO_BITS) + 1;
	localparam int HW  = DW - LO_BITS;
	localparam int NST = 14;
	localparam int TRIG_LAST = 5;
	localparam int LANE_LAST = 13;
	localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

	typedef struct packed {
		logic [11:0]              aw;
		logic [11:0]              ah;
		logic [11:0]              bw;
		logic [11:0]              bh;
		logic signed [HW-1:0]     hx;
		logic signed [HW-1:0]     hy;
		logic [LO_BITS-1:0]       lx;
		logic [LO_BITS-1:0]       ly;
	} geo_t;

	// ------------------------------------------------------------------
	// Flow control. A stage may load when it is empty or when the stage
	// after it loads in the same cycle. The result register is the last
	// stage and only holds while the consumer stalls it.
	// ------------------------------------------------------------------
	logic [NST:1] vld;
	logic [NST:1] en;

	always_comb begin
		en[NST] = !vld[NST] || !out_stall;
		for (int k = NST - 1; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) begin
				vld[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Front end: centre offset from the corners with exact half sizes, and
	// the closed box test used when both are axis aligned and no projection is wanted.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] dx, dy;
	logic signed [DW-1:0] aw8, ah8, bw8, bh8;
	geo_t                 geo_in;
	ctl_t                 ctl_in;

	always_comb begin
		aw8 = DW'($signed({1'b0, a_w})) <<< 8;
		ah8 = DW'($signed({1'b0, a_h})) <<< 8;
		bw8 = DW'($signed({1'b0, b_w})) <<< 8;
		bh8 = DW'($signed({1'b0, b_h})) <<< 8;
		// Half-size difference in Q.8 is (bw - aw) * 128.
		dx  = DW'(b_x) - DW'(a_x) + ((bw8 - aw8) >>> 1);
		dy  = DW'(b_y) - DW'(a_y) + ((bh8 - ah8) >>> 1);

		geo_in.aw = a_w;
		geo_in.ah = a_h;
		geo_in.bw = b_w;
		geo_in.bh = b_h;
		geo_in.hx = dx[DW-1:LO_BITS];
		geo_in.hy = dy[DW-1:LO_BITS];
		geo_in.lx = dx[LO_BITS-1:0];
		geo_in.ly = dy[LO_BITS-1:0];

		ctl_in.want_proj   = want_projections;
		ctl_in.aligned     = !want_projections && (a_angle == '0) && (b_angle == '0);
		ctl_in.aligned_hit = (DW'(a_y) + ah8 >= DW'(b_y)) && (DW'(a_y) <= DW'(b_y) + bh8)
			&& (DW'(a_x) + aw8 >= DW'(b_x)) && (DW'(a_x) <= DW'(b_x) + bw8);
	end

	// Geometry waits beside the sine units; the control word runs to the merge.
	geo_t geo_s [1:TRIG_LAST];
	ctl_t ctl_s [1:LANE_LAST];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			geo_s[1] <= geo_in;
			ctl_s[1] <= ctl_in;
		end
		for (int k = 2; k <= TRIG_LAST; k++) begin
			if (en[k]) begin
				geo_s[k] <= geo_s[k-1];
			end
		end
		for (int k = 2; k <= LANE_LAST; k++) begin
			if (en[k]) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sine and cosine of both angles; cosine is the sine a quarter on.
	// ------------------------------------------------------------------
	logic signed [TRIG_W-1:0] sa, ca, sb, cb;

	orc_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sin_a (
		.clk   (clk),
		.en    (en[TRIG_LAST:1]),
		.angle (a_angle),
		.value (sa)
	);

	orc_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cos_a (
		.clk   (clk),
		.en    (en[TRIG_LAST:1]),
		.angle (a_angle + QUARTER),
		.value (ca)
	);

	orc_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sin_b (
		.clk   (clk),
		.en    (en[TRIG_LAST:1]),
		.angle (b_angle),
		.value (sb)
	);

	orc_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cos_b (
		.clk   (clk),
		.en    (en[TRIG_LAST:1]),
		.angle (b_angle + QUARTER),
		.value (cb)
	);

	// ------------------------------------------------------------------
	// Axis lanes. The axes are the unit frame directions of the
	// first rectangle and then of the second, in that order.
	// ------------------------------------------------------------------
	logic signed [TRIG_W-1:0]      ux [NUM_AXES];
	logic signed [TRIG_W-1:0]      uy [NUM_AXES];
	logic [NUM_AXES-1:0]           gap;
	logic signed [COORD_WIDTH-1:0] vx [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vy [NUM_AXES];

	always_comb begin
		ux[0] = ca;
		uy[0] = sa;
		ux[1] = sa;
		uy[1] = -ca;
		ux[2] = cb;
		uy[2] = sb;
		ux[3] = sb;
		uy[3] = -cb;
	end

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		orc_lane #(
			.COORD_WIDTH (COORD_WIDTH),
			.HI_WIDTH    (HW)
		) u_lane (
			.clk (clk),
			.en  (en[LANE_LAST:TRIG_LAST+1]),
			.ux  (ux[g]),
			.uy  (uy[g]),
			.ca  (ca),
			.sa  (sa),
			.cb  (cb),
			.sb  (sb),
			.aw  (geo_s[TRIG_LAST].aw),
			.ah  (geo_s[TRIG_LAST].ah),
			.bw  (geo_s[TRIG_LAST].bw),
			.bh  (geo_s[TRIG_LAST].bh),
			.hx  (geo_s[TRIG_LAST].hx),
			.hy  (geo_s[TRIG_LAST].hy),
			.lx  (geo_s[TRIG_LAST].lx),
			.ly  (geo_s[TRIG_LAST].ly),
			.gap (gap[g]),
			.vx  (vx[g]),
			.vy  (vy[g])
		);
	end

	// ------------------------------------------------------------------
	// Merge into the result register.
	// ------------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] px [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] py [NUM_AXES];

	orc_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
		.clk   (clk),
		.en    (en[NST]),
		.ctl   (ctl_s[LANE_LAST]),
		.gap   (gap),
		.vx    (vx),
		.vy    (vy),
		.hit   (hit),
		.count (proj_count),
		.px    (px),
		.py    (py)
	);

	assign proj0_x = px[0];
	assign proj0_y = py[0];
	assign proj1_x = px[1];
	assign proj1_y = py[1];
	assign proj2_x = px[2];
	assign proj2_y = py[2];
	assign proj3_x = px[3];
	assign proj3_y = py[3];

endmodule

// ===== rtl/orc_trig.sv =====
// ----------------------------------------------------------------------------
// Pipelined sine unit
// Five-stage quarter-wave polynomial sine with quadrant folding; one
// angle per cycle while the stage enables allow, signed Q1.14 result.
// ----------------------------------------------------------------------------
module orc_trig import orc_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic [4:0]               en,
	input  logic [ANGLE_WIDTH-1:0]   angle,
	output logic signed [TRIG_W-1:0] value
);

	localparam int Q = ANGLE_WIDTH - 2;

	logic [1:0]    quad;
	logic [Q-1:0]  frac;
	logic [Q:0]    frac_fold;
	logic [Q+15:0] frac_scaled;
	logic [15:0]   t;

	// Fold the angle into the first quarter and scale it to Q15.
	always_comb begin
		quad        = angle[ANGLE_WIDTH-1 -: 2];
		frac        = angle[Q-1:0];
		frac_fold   = quad[0] ? (((Q+1)'(1)) << Q) - {1'b0, frac} : {1'b0, frac};
		frac_scaled = {frac_fold, 15'd0} >> Q;
		t           = frac_scaled[15:0];
	end

	logic [15:0] t_s1, t_s2, t_s3;
	logic [30:0] t2_s1, t2_s2;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [56:0] p_s2;
	logic [60:0] q_s3;
	logic [46:0] r_s4;

	logic [29:0]              inner;
	logic [30:0]              inner2;
	logic [47:0]              r_rnd;
	logic signed [TRIG_W-1:0] mag;

	always_comb begin
		inner  = POLY_B - 30'(p_s2[56:30]);
		inner2 = POLY_A - q_s3[60:30];
		r_rnd  = 48'(r_s4) + (48'd1 << 30);
		mag    = signed'(r_rnd[46:31]);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1   <= t;
			t2_s1  <= 31'(32'(t) * 32'(t));
			neg_s1 <= quad[1];
		end
		if (en[1]) begin
			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			neg_s2 <= neg_s1;
			p_s2   <= 57'(t2_s1) * 57'(POLY_C);
		end
		if (en[2]) begin
			t_s3   <= t_s2;
			neg_s3 <= neg_s2;
			q_s3   <= 61'(t2_s2) * 61'(inner);
		end
		if (en[3]) begin
			neg_s4 <= neg_s3;
			r_s4   <= 47'(t_s3) * 47'(inner2);
		end
		if (en[4]) begin
			value <= neg_s4 ? -mag : mag;
		end
	end

endmodule

// ===== rtl/orc_lane.sv =====
// ----------------------------------------------------------------------------
// Separating axis lane
// Projects both rectangles and the centre offset onto one axis, decides
// whether the axis shows a gap and forms the rounded overlap vector.
// ----------------------------------------------------------------------------
module orc_lane import orc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int HI_WIDTH    = HI_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic [7:0]                    en,
	input  logic signed [TRIG_W-1:0]      ux,
	input  logic signed [TRIG_W-1:0]      uy,
	input  logic signed [TRIG_W-1:0]      ca,
	input  logic signed [TRIG_W-1:0]      sa,
	input  logic signed [TRIG_W-1:0]      cb,
	input  logic signed [TRIG_W-1:0]      sb,
	input  logic [11:0]                   aw,
	input  logic [11:0]                   ah,
	input  logic [11:0]                   bw,
	input  logic [11:0]                   bh,
	input  logic signed [HI_WIDTH-1:0]    hx,
	input  logic signed [HI_WIDTH-1:0]    hy,
	input  logic [LO_BITS-1:0]            lx,
	input  logic [LO_BITS-1:0]            ly,
	output logic                          gap,
	output logic signed [COORD_WIDTH-1:0] vx,
	output logic signed [COORD_WIDTH-1:0] vy
);

	localparam int HSW = HI_WIDTH + TRIG_W + 1;
	localparam int LSW = LO_BITS + TRIG_W + 2;
	localparam int EW  = 2 * TRIG_W;
	localparam int PW  = EW + 20;
	localparam int DSW = 45;
	localparam int W   = 60;
	localparam int OVW = 27;
	localparam int MW  = TRIG_W + OVW + 1;
	localparam int RW  = MW - 14;
	localparam logic signed [63:0] VMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN = -(64'sd1 <<< (COORD_WIDTH - 1));
	localparam logic signed [63:0] HLIM = 64'sd1 <<< 22;
	localparam logic signed [DSW-1:0] DSAT = DSW'(64'sd1 <<< 42);

	// Stage 6: dot products of the rectangle frames with the axis.
	logic signed [EW-1:0]     e1a_s6, e2a_s6, e1b_s6, e2b_s6;
	logic signed [HSW-1:0]    hsum_s6;
	logic signed [LSW-1:0]    lsum_s6;
	logic signed [TRIG_W-1:0] ux_s6, uy_s6;
	logic [11:0]              aw_s6, ah_s6, bw_s6, bh_s6;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			e1a_s6  <= EW'(ca) * EW'(ux) + EW'(sa) * EW'(uy);
			e2a_s6  <= EW'(sa) * EW'(ux) - EW'(ca) * EW'(uy);
			e1b_s6  <= EW'(cb) * EW'(ux) + EW'(sb) * EW'(uy);
			e2b_s6  <= EW'(sb) * EW'(ux) - EW'(cb) * EW'(uy);
			hsum_s6 <= HSW'(hx) * HSW'(ux) + HSW'(hy) * HSW'(uy);
			lsum_s6 <= LSW'($signed({1'b0, lx})) * LSW'(ux)
				+ LSW'($signed({1'b0, ly})) * LSW'(uy);
			ux_s6   <= ux;
			uy_s6   <= uy;
			aw_s6   <= aw;
			ah_s6   <= ah;
			bw_s6   <= bw;
			bh_s6   <= bh;
		end
	end

	// Stage 7: scale by half extents; assemble the saturated offset projection.
	logic signed [63:0]       hs64;
	logic signed [DSW-1:0]    d22;
	logic signed [PW-1:0]     pa_s7, qa_s7, pb_s7, qb_s7;
	logic signed [W-1:0]      d_s7;
	logic signed [TRIG_W-1:0] ux_s7, uy_s7;

	always_comb begin
		hs64 = 64'(hsum_s6);
		if (hs64 > HLIM) begin
			d22 = DSAT;
		end else if (hs64 < -HLIM) begin
			d22 = -DSAT;
		end else begin
			d22 = (DSW'(hsum_s6) <<< LO_BITS) + DSW'(lsum_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pa_s7 <= PW'(e1a_s6) * PW'($signed({1'b0, aw_s6, 7'd0}));
			qa_s7 <= PW'(e2a_s6) * PW'($signed({1'b0, ah_s6, 7'd0}));
			pb_s7 <= PW'(e1b_s6) * PW'($signed({1'b0, bw_s6, 7'd0}));
			qb_s7 <= PW'(e2b_s6) * PW'($signed({1'b0, bh_s6, 7'd0}));
			d_s7  <= W'(d22) <<< 14;
			ux_s7 <= ux_s6;
			uy_s7 <= uy_s6;
		end
	end

	// Stage 8: projected radii.
	logic signed [PW-1:0]     pa_abs, qa_abs, pb_abs, qb_abs;
	logic signed [W-1:0]      ra_s8, rb_s8, d_s8;
	logic signed [TRIG_W-1:0] ux_s8, uy_s8;

	always_comb begin
		pa_abs = (pa_s7 < 0) ? -pa_s7 : pa_s7;
		qa_abs = (qa_s7 < 0) ? -qa_s7 : qa_s7;
		pb_abs = (pb_s7 < 0) ? -pb_s7 : pb_s7;
		qb_abs = (qb_s7 < 0) ? -qb_s7 : qb_s7;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ra_s8 <= W'(pa_abs) + W'(qa_abs);
			rb_s8 <= W'(pb_abs) + W'(qb_abs);
			d_s8  <= d_s7;
			ux_s8 <= ux_s7;
			uy_s8 <= uy_s7;
		end
	end

	// Stage 9: interval ends of the second rectangle relative to the first.
	logic signed [W-1:0]      dp_s9, dm_s9, ra_s9, nra_s9;
	logic signed [TRIG_W-1:0] ux_s9, uy_s9;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dp_s9  <= d_s8 + rb_s8;
			dm_s9  <= d_s8 - rb_s8;
			ra_s9  <= ra_s8;
			nra_s9 <= -ra_s8;
			ux_s9  <= ux_s8;
			uy_s9  <= uy_s8;
		end
	end

	// Stage 10: gap decision and overlap interval. Touching is no gap.
	logic                     gap_s10;
	logic signed [W-1:0]      lo_s10, hi_s10;
	logic signed [TRIG_W-1:0] ux_s10, uy_s10;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			gap_s10 <= (nra_s9 > dp_s9) || (dm_s9 > ra_s9);
			lo_s10  <= (dm_s9 > nra_s9) ? dm_s9 : nra_s9;
			hi_s10  <= (dp_s9 < ra_s9) ? dp_s9 : ra_s9;
			ux_s10  <= ux_s9;
			uy_s10  <= uy_s9;
		end
	end

	// Stage 11: overlap length truncated to Q.8.
	logic [W-1:0]             diff;
	logic                     gap_s11;
	logic [OVW-1:0]           ov8_s11;
	logic signed [TRIG_W-1:0] ux_s11, uy_s11;

	assign diff = unsigned'(hi_s10 - lo_s10);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			gap_s11 <= gap_s10;
			ov8_s11 <= diff[OVW+27:28];
			ux_s11  <= ux_s10;
			uy_s11  <= uy_s10;
		end
	end

	// Stage 12: overlap times the axis components.
	logic                 gap_s12;
	logic signed [MW-1:0] mx_s12, my_s12;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			gap_s12 <= gap_s11;
			mx_s12  <= MW'(ux_s11) * MW'($signed({1'b0, ov8_s11}));
			my_s12  <= MW'(uy_s11) * MW'($signed({1'b0, ov8_s11}));
		end
	end

	// Stage 13: round to Q.8 and clamp to the coordinate range.
	logic signed [MW-1:0] mx_rnd, my_rnd;
	logic signed [63:0]   rx64, ry64, sx64, sy64;

	always_comb begin
		mx_rnd = (mx_s12 + MW'(64'sd8192)) >>> 14;
		my_rnd = (my_s12 + MW'(64'sd8192)) >>> 14;
		rx64   = 64'(RW'(mx_rnd));
		ry64   = 64'(RW'(my_rnd));
		sx64   = (rx64 > VMAX) ? VMAX : ((rx64 < VMIN) ? VMIN : rx64);
		sy64   = (ry64 > VMAX) ? VMAX : ((ry64 < VMIN) ? VMIN : ry64);
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			gap <= gap_s12;
			vx  <= COORD_WIDTH'(sx64);
			vy  <= COORD_WIDTH'(sy64);
		end
	end

endmodule

// ===== rtl/orc_merge.sv =====
// ----------------------------------------------------------------------------
// Lane merge
// Finds the first axis with a gap and, when projections are wanted,
// packs the overlap vectors of the axes before it into the result register.
// ----------------------------------------------------------------------------
module orc_merge import orc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  ctl_t                          ctl,
	input  logic [NUM_AXES-1:0]           gap,
	input  logic signed [COORD_WIDTH-1:0] vx [NUM_AXES],
	input  logic signed [COORD_WIDTH-1:0] vy [NUM_AXES],
	output logic                          hit,
	output logic [2:0]                    count,
	output logic signed [COORD_WIDTH-1:0] px [NUM_AXES],
	output logic signed [COORD_WIDTH-1:0] py [NUM_AXES]
);

	logic [2:0] first;
	logic       full_test;

	// Lowest lane that found a gap; NUM_AXES when none did.
	always_comb begin
		first = 3'(NUM_AXES);
		for (int i = NUM_AXES - 1; i >= 0; i--) begin
			if (gap[i]) begin
				first = 3'(i);
			end
		end
		full_test = !ctl.aligned;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit   <= full_test ? (first == 3'(NUM_AXES)) : ctl.aligned_hit;
			count <= (full_test && ctl.want_proj) ? first : 3'd0;
			for (int k = 0; k < NUM_AXES; k++) begin
				if (full_test && ctl.want_proj && (3'(k) < first)) begin
					px[k] <= vx[k];
					py[k] <= vy[k];
				end else begin
					px[k] <= '0;
					py[k] <= '0;
				end
			end
		end
	end

endmodule
